[rtl/conv3x3_zero_pad_stream_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 convolution stream unit
// Wraps concurrent checks so they drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_ZERO_PAD_STREAM_UNIT_MACROS_SVH
`define CONV3X3_ZERO_PAD_STREAM_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante
`define C3ZP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c3zp: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define C3ZP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c3zp: next-cycle check failed");

`else

`define C3ZP_ASSERT_IMPL(lbl, ante, cons)
`define C3ZP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/c3zp_pkg.sv]
// ----------------------------------------------------------------------------
// c3zp_pkg
// Types, register codes and helpers shared by the 3x3 convolution stream unit.
// ----------------------------------------------------------------------------
package c3zp_pkg;

    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 32;
    localparam int PART_W     = 34;
    localparam int SUM_W      = 36;
    localparam int KSIZE      = 3;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int POS_W      = 10;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

    // Reset values: identity kernel (center 1.0 in Q2.13), VGA frame
    localparam logic [CFG_W-1:0] KERNEL_TOP_RESET   = 48'h0000_0000_0000;
    localparam logic [CFG_W-1:0] KERNEL_MID_RESET   = 48'h0000_2000_0000;
    localparam logic [CFG_W-1:0] KERNEL_BOT_RESET   = 48'h0000_0000_0000;
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

    typedef struct packed {
        logic                    req_type;
        logic signed [PIX_W-1:0] pixel_value;
    } c3zp_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] conv_sum;
        logic [POS_W-1:0]        out_col;
        logic [POS_W-1:0]        out_row;
        logic                    frame_done;
    } c3zp_out_t;

    typedef logic signed [PIX_W-1:0] pix_t;

    // Window indexed [row][col], row 0 is the oldest line, col 2 the newest pixel
    typedef pix_t [KSIZE-1:0][KSIZE-1:0] win_t;

    typedef struct packed {
        win_t             taps;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             done;
    } c3zp_tap_t;

    typedef struct packed {
        logic [CFG_W-1:0] k_top;
        logic [CFG_W-1:0] k_mid;
        logic [CFG_W-1:0] k_bot;
    } kernel_t;

    // Pick one signed Q2.13 coefficient, column 0 in the low bits of a row
    function automatic logic signed [COEF_W-1:0] coef(input kernel_t k,
                                                      input int unsigned row,
                                                      input int unsigned col);
        logic [CFG_W-1:0] rv;
        case (row)
            0:       rv = k.k_top;
            1:       rv = k.k_mid;
            default: rv = k.k_bot;
        endcase
        return rv[COEF_W*col +: COEF_W];
    endfunction

endpackage

[rtl/c3zp_ram.sv]
// ----------------------------------------------------------------------------
// c3zp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module c3zp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/c3zp_window.sv]
// ----------------------------------------------------------------------------
// c3zp_window
// Raster position tracking, two line stores and the 3x3 window register.
// Emits one window with its output position for each completed neighborhood.
// ----------------------------------------------------------------------------
`include "conv3x3_zero_pad_stream_unit_macros.svh"

module c3zp_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  c3zp_pkg::c3zp_in_t         in_data,
    input  logic                       restart,
    input  logic [c3zp_pkg::DIM_W-1:0] image_width,
    input  logic [c3zp_pkg::DIM_W-1:0] image_height,
    output logic                       tap_valid,
    input  logic                       tap_ready,
    output c3zp_pkg::c3zp_tap_t        tap_data
);
    import c3zp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // Frame position and window state
    logic [CW-1:0]    col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [CW-1:0]    ecol_reg, ecol_next;
    logic [POS_W-1:0] erow_reg, erow_next;
    win_t             win_reg, win_next;

    // Same-address bypass for the line store reads
    logic             byp_reg;
    pix_t             byp_top_reg;
    pix_t             byp_mid_reg;

    // Window output stage
    logic             tap_v_reg;
    c3zp_tap_t        tap_reg;

    logic             acc;
    logic [CW-1:0]    wm1;
    logic [POS_W-1:0] hm1;
    logic [DIM_W-1:0] h_val;
    logic             bad;
    logic [CW-1:0]    c;
    logic [DIM_W-1:0] r;
    logic [CW-1:0]    ec;
    logic [POS_W-1:0] er;
    win_t             wbase;
    win_t             win_step;
    win_t             emit_win;
    pix_t             v;
    pix_t             top_q;
    pix_t             mid_q;
    pix_t             top_rd;
    pix_t             mid_rd;
    pix_t             top_px;
    pix_t             mid_px;
    logic             emit;
    logic             done;
    logic             frame_end;
    logic             last_col;
    logic [CW-1:0]    c_adv;
    logic [DIM_W-1:0] r_adv;

    assign acc = in_valid && in_ready;

    // Clamp the frame size: zero counts as one, oversize to the maximum
    always_comb
    begin
        if (image_width == '0)
        begin
            wm1 = '0;
        end
        else if (32'(image_width) > MAX_WIDTH)
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(image_width - 11'd1);
        end

        if (image_height == '0)
        begin
            hm1 = '0;
        end
        else if (32'(image_height) > MAX_HEIGHT)
        begin
            hm1 = POS_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1 = POS_W'(image_height - 11'd1);
        end
        h_val = {1'b0, hm1} + 11'd1;
    end

    // Line store reads, with bypass when the last write hit the read address
    assign top_rd = byp_reg ? byp_top_reg : top_q;
    assign mid_rd = byp_reg ? byp_mid_reg : mid_q;

    // Step logic for one accepted transfer
    always_comb
    begin
        bad   = (col_reg > wm1) || (row_reg > (h_val + 11'd1));
        c     = bad ? '0 : col_reg;
        r     = bad ? '0 : row_reg;
        ec    = bad ? '0 : ecol_reg;
        er    = bad ? '0 : erow_reg;
        wbase = bad ? '0 : win_reg;

        // Drop pixel values for flush ticks and the drain rows
        v      = (in_data.req_type || (r >= h_val)) ? '0 : in_data.pixel_value;
        top_px = (r >= 11'd2) ? top_rd : '0;
        mid_px = (r >= 11'd1) ? mid_rd : '0;

        // Advance the window one column
        for (int a = 0; a < KSIZE; a++)
        begin
            emit_win[a][0] = wbase[a][1];
            emit_win[a][1] = wbase[a][2];
            emit_win[a][2] = '0;
        end

        if (c == '0)
        begin
            // Row start: the right border of the previous row closes with zeros
            emit     = (r >= 11'd2);
            win_step = '0;
            win_step[0][2] = top_px;
            win_step[1][2] = mid_px;
            win_step[2][2] = v;
        end
        else
        begin
            emit     = (r >= 11'd1);
            win_step = emit_win;
            win_step[0][2] = top_px;
            win_step[1][2] = mid_px;
            win_step[2][2] = v;
            emit_win = win_step;
        end

        done      = emit && (ec == wm1) && (er == hm1);
        frame_end = emit && (done || (r > h_val));

        last_col = (c == wm1);
        c_adv    = last_col ? '0 : c + 1'b1;
        r_adv    = last_col ? r + 11'd1 : r;

        // Hold by default
        col_next  = col_reg;
        row_next  = row_reg;
        ecol_next = ecol_reg;
        erow_next = erow_reg;
        win_next  = win_reg;

        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            ecol_next = '0;
            erow_next = '0;
            win_next  = '0;
        end
        else if (acc)
        begin
            if (frame_end)
            begin
                col_next  = '0;
                row_next  = '0;
                ecol_next = '0;
                erow_next = '0;
                win_next  = '0;
            end
            else
            begin
                col_next = c_adv;
                row_next = r_adv;
                win_next = win_step;
                if (emit)
                begin
                    if (ec == wm1)
                    begin
                        ecol_next = '0;
                        erow_next = er + 1'b1;
                    end
                    else
                    begin
                        ecol_next = ec + 1'b1;
                        erow_next = er;
                    end
                end
                else
                begin
                    ecol_next = ec;
                    erow_next = er;
                end
            end
        end
    end

    // Line stores: top holds row r-2, mid holds row r-1, read ahead at the next column
    c3zp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_top_line (
        .clk   (clk),
        .we    (acc),
        .waddr (c),
        .wdata (mid_px),
        .raddr (col_next),
        .rdata (top_q)
    );

    c3zp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_mid_line (
        .clk   (clk),
        .we    (acc),
        .waddr (c),
        .wdata (v),
        .raddr (col_next),
        .rdata (mid_q)
    );

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ecol_reg <= '0;
            erow_reg <= '0;
            win_reg  <= '0;
            byp_reg  <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ecol_reg <= ecol_next;
            erow_reg <= erow_next;
            win_reg  <= win_next;
            byp_reg  <= acc && (c == col_next);
        end
    end

    // Bypass data
    always_ff @(posedge clk)
    begin
        byp_top_reg <= mid_px;
        byp_mid_reg <= v;
    end

    // Window output stage, refilled when empty or while the next stage takes the current one
    assign in_ready = !tap_v_reg || tap_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            tap_v_reg <= acc && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && emit && in_ready)
        begin
            tap_reg.taps <= emit_win;
            tap_reg.col  <= POS_W'(ec);
            tap_reg.row  <= er;
            tap_reg.done <= done;
        end
    end

    assign tap_valid = tap_v_reg;
    assign tap_data  = tap_reg;

    `C3ZP_ASSERT_IMPL(a_col_in_frame, 1'b1, col_reg <= wm1)
    `C3ZP_ASSERT_NEXT(a_frame_end_clears, acc && frame_end, col_reg == '0 && row_reg == '0)

endmodule

[rtl/c3zp_mac.sv]
// ----------------------------------------------------------------------------
// c3zp_mac
// Nine parallel coefficient multiplies, a registered adder tree and the
// result register.
// ----------------------------------------------------------------------------
`include "conv3x3_zero_pad_stream_unit_macros.svh"

module c3zp_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tap_valid,
    output logic                tap_ready,
    input  c3zp_pkg::c3zp_tap_t tap_data,
    input  c3zp_pkg::kernel_t   kernel,
    output logic                out_valid,
    input  logic                out_ready,
    output c3zp_pkg::c3zp_out_t out_data
);
    import c3zp_pkg::*;

    // Product stage
    logic                     s2_v_reg;
    logic signed [PROD_W-1:0] prod_reg [KSIZE][KSIZE];
    logic [POS_W-1:0]         s2_col_reg;
    logic [POS_W-1:0]         s2_row_reg;
    logic                     s2_done_reg;

    // Row sum stage
    logic                     s3_v_reg;
    logic signed [PART_W-1:0] part_reg [KSIZE];
    logic [POS_W-1:0]         s3_col_reg;
    logic [POS_W-1:0]         s3_row_reg;
    logic                     s3_done_reg;

    // Result stage
    logic                     out_v_reg;
    c3zp_out_t                out_reg;

    logic                     adv2;
    logic                     adv3;
    logic                     adv4;
    logic signed [PROD_W-1:0] prod [KSIZE][KSIZE];
    logic signed [PART_W-1:0] part [KSIZE];
    logic signed [SUM_W-1:0]  total;

    // Each stage advances when the next one is empty or moving
    assign adv4      = !out_v_reg || out_ready;
    assign adv3      = !s3_v_reg || adv4;
    assign adv2      = !s2_v_reg || adv3;
    assign tap_ready = adv2;

    // Flipped kernel: window[a][b] meets k[2-a][2-b]
    always_comb
    begin
        for (int a = 0; a < KSIZE; a++)
        begin
            for (int b = 0; b < KSIZE; b++)
            begin
                prod[a][b] = $signed(tap_data.taps[a][b])
                           * coef(kernel, KSIZE - 1 - a, KSIZE - 1 - b);
            end
        end
    end

    // Sum each window row
    always_comb
    begin
        for (int a = 0; a < KSIZE; a++)
        begin
            part[a] = PART_W'(prod_reg[a][0]) + PART_W'(prod_reg[a][1])
                    + PART_W'(prod_reg[a][2]);
        end
    end

    assign total = SUM_W'(part_reg[0]) + SUM_W'(part_reg[1]) + SUM_W'(part_reg[2]);

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv2)
            begin
                s2_v_reg <= tap_valid;
            end
            if (adv3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (adv4)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv2 && tap_valid)
        begin
            prod_reg    <= prod;
            s2_col_reg  <= tap_data.col;
            s2_row_reg  <= tap_data.row;
            s2_done_reg <= tap_data.done;
        end
        if (adv3 && s2_v_reg)
        begin
            part_reg    <= part;
            s3_col_reg  <= s2_col_reg;
            s3_row_reg  <= s2_row_reg;
            s3_done_reg <= s2_done_reg;
        end
        if (adv4 && s3_v_reg)
        begin
            out_reg.conv_sum   <= total;
            out_reg.out_col    <= s3_col_reg;
            out_reg.out_row    <= s3_row_reg;
            out_reg.frame_done <= s3_done_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    `C3ZP_ASSERT_NEXT(a_sum_stage_holds, s3_v_reg && !adv4, s3_v_reg && $stable(s3_col_reg))

endmodule

[rtl/conv3x3_zero_pad_stream_unit.sv]
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_stream_unit
// Streaming 3x3 convolution with zero padding over a raster-order image.
// ----------------------------------------------------------------------------
// Usage:
//  Pixels enter on the in channel (valid/ready) in raster order, one transfer
//  per clock at most. req_type marks flush ticks that feed a zero pixel; each
//  frame is width*height pixels followed by width+1 flush ticks, after which
//  the frame restarts by itself.
//  Output pixel (x,y) becomes known on the input transfer width+1 positions
//  after pixel (x,y), and reaches the out channel through registers: the
//  window register loads on the transfer edge, then the product, row-sum and
//  result registers follow. Sustained rate is one input and one result per
//  clock while the receiver keeps taking results; the nine multiplies run
//  in parallel and the two line stores are read one column ahead, so nothing
//  iterates.
//  A stalled receiver holds the result register; stages behind it keep
//  taking transfers until they are full, then in_ready drops.
//  Reset clears the counters and window and loads an identity kernel and a
//  640x480 frame; no clearing pass is run, since line store reads above the
//  first rows are forced to zero. Writing width or height restarts the frame.
// ----------------------------------------------------------------------------
`include "conv3x3_zero_pad_stream_unit_macros.svh"

module conv3x3_zero_pad_stream_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  c3zp_pkg::c3zp_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output c3zp_pkg::c3zp_out_t            out_data,
    input  logic                           cfg_wr_en,
    input  logic [c3zp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [c3zp_pkg::CFG_W-1:0]     cfg_wdata
);
    import c3zp_pkg::*;

    kernel_t          kernel_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             restart;
    logic             tap_valid;
    logic             tap_ready;
    c3zp_tap_t        tap_data;

    // A size write restarts the frame
    assign restart = cfg_wr_en
                  && ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg.k_top <= KERNEL_TOP_RESET;
            kernel_reg.k_mid <= KERNEL_MID_RESET;
            kernel_reg.k_bot <= KERNEL_BOT_RESET;
            width_reg        <= IMAGE_WIDTH_RESET;
            height_reg       <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_KERNEL_TOP:   kernel_reg.k_top <= cfg_wdata;
                REG_KERNEL_MID:   kernel_reg.k_mid <= cfg_wdata;
                REG_KERNEL_BOT:   kernel_reg.k_bot <= cfg_wdata;
                REG_IMAGE_WIDTH:  width_reg        <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg       <= cfg_wdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    c3zp_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .restart      (restart),
        .image_width  (width_reg),
        .image_height (height_reg),
        .tap_valid    (tap_valid),
        .tap_ready    (tap_ready),
        .tap_data     (tap_data)
    );

    c3zp_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_valid (tap_valid),
        .tap_ready (tap_ready),
        .tap_data  (tap_data),
        .kernel    (kernel_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `C3ZP_ASSERT_IMPL(a_ready_when_drained, !out_valid, in_ready)

endmodule

[test/tb_conv3x3_zero_pad_stream_unit.sv]
// ----------------------------------------------------------------------------
// tb_conv3x3_zero_pad_stream_unit
// Self-checking bench for the streaming 3x3 zero-padded convolution. A
// directed plan of register writes and pixels runs first. Some of its results
// are typed in by hand for the identity kernel. Random frames follow under
// four handshake idling patterns, with one long receiver hold-off and short
// runs at the largest frame sizes. Each output transfer is compared field by
// field with its typed result or with a cycle-free copy of the convolution
// that is kept in step with the input transfers.
// ----------------------------------------------------------------------------
module tb_conv3x3_zero_pad_stream_unit;

    import c3zp_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 12;
    localparam int END_WAIT      = 20000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 320;
    localparam int CLAMP_ITEMS   = 30;
    localparam int MAX_PRINTS    = 40;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Indexes past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    c3zp_in_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    c3zp_out_t            out_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int   cycle_count    = 0;
    int   mismatches     = 0;
    int   items_sent     = 0;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    logic sink_blocked   = 1'b0;
    bit   hold_req       = 1'b0;

    // Output pixels owed by the block, oldest first
    c3zp_out_t sums_due[$];

    conv3x3_zero_pad_stream_unit #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Convolution copy: registers, line buffers, window and frame position
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] kern_row [0:KSIZE-1];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    pix_t             line_mem [0:2*MAX_W-1];
    pix_t             tap [0:KSIZE-1][0:KSIZE-1];
    int unsigned      feed_col, feed_row, res_col, res_row;

    function automatic int unsigned eff_width();
        if (width_reg == '0)
            return 1;
        if (width_reg > MAX_W)
            return MAX_W;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == '0)
            return 1;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return height_reg;
    endfunction

    // Clear window and counters; line buffers keep their contents
    function automatic void rewind_frame();
        for (int a = 0; a < KSIZE; a++)
            for (int b = 0; b < KSIZE; b++)
                tap[a][b] = '0;
        feed_col = 0;
        feed_row = 0;
        res_col  = 0;
        res_row  = 0;
    endfunction

    function automatic void reset_conv_copy();
        kern_row[0] = KERNEL_TOP_RESET;
        kern_row[1] = KERNEL_MID_RESET;
        kern_row[2] = KERNEL_BOT_RESET;
        width_reg   = IMAGE_WIDTH_RESET;
        height_reg  = IMAGE_HEIGHT_RESET;
        for (int i = 0; i < 2*MAX_W; i++)
            line_mem[i] = '0;
        rewind_frame();
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
        case (idx)
            REG_KERNEL_TOP:   kern_row[0] = data;
            REG_KERNEL_MID:   kern_row[1] = data;
            REG_KERNEL_BOT:   kern_row[2] = data;
            REG_IMAGE_WIDTH:
            begin
                width_reg = data[DIM_W-1:0];
                rewind_frame();
            end
            REG_IMAGE_HEIGHT:
            begin
                height_reg = data[DIM_W-1:0];
                rewind_frame();
            end
            default: ;
        endcase
    endfunction

    // Flipped kernel: window row a, col b meets coefficient (2-a, 2-b)
    function automatic logic signed [SUM_W-1:0] tap_sum();
        longint           acc, p, q;
        logic [CFG_W-1:0] krow;
        acc = 0;
        for (int a = 0; a < KSIZE; a++)
            for (int b = 0; b < KSIZE; b++)
            begin
                krow = kern_row[KSIZE-1-a];
                p    = tap[a][b];
                q    = $signed(krow[COEF_W*(KSIZE-1-b) +: COEF_W]);
                acc += p * q;
            end
        return acc[SUM_W-1:0];
    endfunction

    function automatic void shift_taps(input pix_t t, input pix_t m, input pix_t bt);
        for (int a = 0; a < KSIZE; a++)
        begin
            tap[a][0] = tap[a][1];
            tap[a][1] = tap[a][2];
        end
        tap[0][2] = t;
        tap[1][2] = m;
        tap[2][2] = bt;
    endfunction

    // Advance by one input pixel; return 1 when it completes an output pixel
    function automatic bit convolve_pixel(input c3zp_in_t px, output c3zp_out_t res);
        int unsigned             w, h, c, r;
        pix_t                    v, top, mid;
        bit                      emit, last;
        logic signed [SUM_W-1:0] s;
        w    = eff_width();
        h    = eff_height();
        emit = 1'b0;
        s    = '0;
        res  = '0;
        if (feed_col >= w || feed_row > h + 1)
            rewind_frame();
        c = feed_col;
        r = feed_row;

        // Flush ticks and anything past the last row feed a zero pixel
        if (px.req_type == REQ_FLUSH || r >= h)
            v = '0;
        else
            v = px.pixel_value;
        top = (r >= 2) ? line_mem[c] : '0;
        mid = (r >= 1) ? line_mem[MAX_W + c] : '0;
        line_mem[c]         = mid;
        line_mem[MAX_W + c] = v;

        if (c == 0)
        begin
            // Close the previous row against the right-hand zero pad
            if (r >= 2)
            begin
                shift_taps('0, '0, '0);
                s    = tap_sum();
                emit = 1'b1;
            end
            for (int a = 0; a < KSIZE; a++)
            begin
                tap[a][0] = '0;
                tap[a][1] = '0;
            end
            tap[0][2] = top;
            tap[1][2] = mid;
            tap[2][2] = v;
        end
        else
        begin
            shift_taps(top, mid, v);
            if (r >= 1)
            begin
                s    = tap_sum();
                emit = 1'b1;
            end
        end

        last = emit && res_col == w - 1 && res_row == h - 1;
        if (emit)
        begin
            res.conv_sum   = s;
            res.out_col    = res_col[POS_W-1:0];
            res.out_row    = res_row[POS_W-1:0];
            res.frame_done = last;
        end

        if (last || (emit && r >= h + 1))
            rewind_frame();
        else
        begin
            if (emit)
            begin
                res_col++;
                if (res_col == w)
                begin
                    res_col = 0;
                    res_row++;
                end
            end
            c++;
            if (c == w)
            begin
                c = 0;
                r++;
            end
            feed_col = c;
            feed_row = r;
        end
        return emit;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting and output checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge clk)
    begin : result_check
        c3zp_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sums_due.size() == 0)
                flag_mismatch($sformatf("unexpected output pixel (%0d,%0d)",
                                        out_data.out_col, out_data.out_row));
            else
            begin
                want = sums_due.pop_front();
                if (out_data.conv_sum !== want.conv_sum)
                    flag_mismatch($sformatf("conv_sum at (%0d,%0d): got %0d, want %0d",
                                            want.out_col, want.out_row,
                                            out_data.conv_sum, want.conv_sum));
                if (out_data.out_col !== want.out_col)
                    flag_mismatch($sformatf("out_col: got %0d, want %0d",
                                            out_data.out_col, want.out_col));
                if (out_data.out_row !== want.out_row)
                    flag_mismatch($sformatf("out_row: got %0d, want %0d",
                                            out_data.out_row, want.out_row));
                if (out_data.frame_done !== want.frame_done)
                    flag_mismatch($sformatf("frame_done at (%0d,%0d): got %0b, want %0b",
                                            want.out_col, want.out_row,
                                            out_data.frame_done, want.frame_done));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : sink_ready
        forever
        begin
            @(posedge clk);
            out_ready <= !sink_blocked && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin : sink_hold
        forever
        begin
            wait (hold_req);
            @(posedge clk);
            sink_blocked <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            sink_blocked <= 1'b0;
            hold_req = 1'b0;
        end
    end

    initial
    begin : watchdog
        wait (cycle_count == CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender and register writes
    // ------------------------------------------------------------------------
    // Offer one pixel, hold it until the transfer, then log what it owes
    task automatic send_pixel(input c3zp_in_t px, input bit typed, input c3zp_out_t typed_res);
        c3zp_out_t res;
        bit        emitted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        emitted = convolve_pixel(px, res);
        if (typed)
            sums_due.push_back(typed_res);
        else if (emitted)
            sums_due.push_back(res);
        items_sent++;
    endtask

    // Drop valid and let the pipeline empty, including pixels that owe nothing
    task automatic settle();
        in_valid <= 1'b0;
        while (sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        apply_reg_write(idx, data);
        @(posedge clk);
    endtask

    // Size write with junk above the 11-bit field now and then
    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        logic [CFG_W-1:0] data;
        data = {16'($urandom), $urandom};
        if ($urandom_range(3) != 0)
            data[CFG_W-1:DIM_W] = '0;
        data[DIM_W-1:0] = DIM_W'(val);
        write_reg(idx, data);
    endtask

    function automatic pix_t rand_pixel();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_coef_row();
        logic [CFG_W-1:0] kr;
        for (int k = 0; k < KSIZE; k++)
            case ($urandom_range(5))
                0:       kr[COEF_W*k +: COEF_W] = 16'h8000;
                1:       kr[COEF_W*k +: COEF_W] = 16'h7FFF;
                2:       kr[COEF_W*k +: COEF_W] = 16'h2000;
                default: kr[COEF_W*k +: COEF_W] = 16'($urandom);
            endcase
        return kr;
    endfunction

    // One frame of random pixels and its flush ticks; a broken frame is cut
    // short or runs long
    task automatic run_frame(input bit broken);
        int unsigned w, h, total, n;
        c3zp_in_t    px;
        w     = eff_width();
        h     = eff_height();
        total = w * h + w + 1;
        n     = broken ? $urandom_range(total + w, 1) : total;
        for (int i = 0; i < n; i++)
        begin
            if (i < w * h)
                px.req_type = ($urandom_range(99) < 8) ? REQ_FLUSH : REQ_PIXEL;
            else
                px.req_type = ($urandom_range(99) < 15) ? REQ_PIXEL : REQ_FLUSH;
            px.pixel_value = rand_pixel();
            send_pixel(px, 1'b0, '0);
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
            1:       begin src_idle_pct = 47; sink_stall_pct <= 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct <= 47; end
            default: begin src_idle_pct = 30; sink_stall_pct <= 30; end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Directed plan rows
    // ------------------------------------------------------------------------
    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        c3zp_in_t             px;
        bit                   typed;
        c3zp_out_t            res;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        plan_row_t r;
        r          = '{default: '0};
        r.is_write = 1'b1;
        r.idx      = idx;
        r.data     = data;
        return r;
    endfunction

    function automatic plan_row_t px_row(input logic kind, input int value);
        plan_row_t r;
        r                = '{default: '0};
        r.px.req_type    = kind;
        r.px.pixel_value = 16'(value);
        return r;
    endfunction

    function automatic plan_row_t px_row_res(input logic kind, input int value,
                                             input longint sum, input int col,
                                             input int row, input bit done);
        plan_row_t r;
        r                  = px_row(kind, value);
        r.typed            = 1'b1;
        r.res.conv_sum     = 36'(sum);
        r.res.out_col      = POS_W'(col);
        r.res.out_row      = POS_W'(row);
        r.res.frame_done   = done;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        bit       broken;
        bit       need_restart;
        int       mode_start;
        int       drain_wait;
        c3zp_in_t px;

        reset_conv_copy();
        set_idling(0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // 3x2 frame on the reset identity kernel: each result is the pixel
        // times 1.0 in Q2.13, width+1 transfers after that pixel
        plan.push_back(reg_row(REG_IMAGE_WIDTH, 48'd3));
        plan.push_back(reg_row(REG_IMAGE_HEIGHT, 48'd2));
        plan.push_back(px_row(REQ_PIXEL, 32767));
        plan.push_back(px_row(REQ_PIXEL, -32768));
        plan.push_back(px_row(REQ_PIXEL, 5));
        plan.push_back(px_row(REQ_PIXEL, -1));
        // flush inside the image: value is ignored, zero pixel goes in
        plan.push_back(px_row_res(REQ_FLUSH, 7777, 268427264, 0, 0, 1'b0));
        plan.push_back(px_row_res(REQ_PIXEL, -32768, -268435456, 1, 0, 1'b0));
        plan.push_back(px_row_res(REQ_FLUSH, 0, 40960, 2, 0, 1'b0));
        // real pixel in the drain phase counts as a flush
        plan.push_back(px_row_res(REQ_PIXEL, 1234, -8192, 0, 1, 1'b0));
        plan.push_back(px_row_res(REQ_FLUSH, -1, 0, 1, 1, 1'b0));
        plan.push_back(px_row_res(REQ_FLUSH, 0, -268435456, 2, 1, 1'b1));

        // Extreme coefficients and pixels, a write to a spare index, 2x3 frame;
        // stale line data from the last frame must read as zero
        plan.push_back(reg_row(REG_KERNEL_TOP, 48'h8000_7FFF_8000));
        plan.push_back(reg_row(REG_KERNEL_MID, 48'h7FFF_8000_7FFF));
        plan.push_back(reg_row(REG_KERNEL_BOT, 48'h0001_FFFF_8000));
        plan.push_back(reg_row(REG_SPARE_LAST, '1));
        plan.push_back(reg_row(REG_IMAGE_WIDTH, 48'd2));
        plan.push_back(reg_row(REG_IMAGE_HEIGHT, 48'd3));
        plan.push_back(px_row(REQ_PIXEL, 32767));
        plan.push_back(px_row(REQ_PIXEL, -32768));
        plan.push_back(px_row(REQ_PIXEL, -32768));
        plan.push_back(px_row(REQ_PIXEL, 32767));
        plan.push_back(px_row(REQ_PIXEL, 32767));
        plan.push_back(px_row(REQ_PIXEL, -32768));
        plan.push_back(px_row(REQ_FLUSH, 0));
        plan.push_back(px_row(REQ_FLUSH, 0));
        plan.push_back(px_row(REQ_FLUSH, 0));

        foreach (plan[i])
        begin
            if (plan[i].is_write)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_pixel(plan[i].px, plan[i].typed, plan[i].res);
        end

        // Random frames under each idling pattern
        need_restart = 1'b1;
        for (int mode = 0; mode < 4; mode++)
        begin
            set_idling(mode);
            if (mode == 0)
            begin
                // Hold the receiver off while a frame streams in at full rate
                write_size(REG_IMAGE_WIDTH, 30);
                write_size(REG_IMAGE_HEIGHT, 4);
                settle();
                hold_req = 1'b1;
                run_frame(1'b0);
            end
            mode_start = items_sent;
            while (items_sent - mode_start < RANDOM_ITEMS / 4)
            begin
                if (need_restart || $urandom_range(2) == 0)
                begin
                    write_size(REG_IMAGE_WIDTH, $urandom_range(6));
                    write_size(REG_IMAGE_HEIGHT, $urandom_range(6));
                end
                if ($urandom_range(3) == 0)
                    case ($urandom_range(2))
                        0:       write_reg(REG_KERNEL_TOP, rand_coef_row());
                        1:       write_reg(REG_KERNEL_MID, rand_coef_row());
                        default: write_reg(REG_KERNEL_BOT, rand_coef_row());
                    endcase
                if ($urandom_range(15) == 0)
                    write_reg(3'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                              {16'($urandom), $urandom});
                if ($urandom_range(11) == 0)
                    write_size(REG_IMAGE_WIDTH, 8 + $urandom_range(32));
                broken = ($urandom_range(9) == 0);
                run_frame(broken);
                need_restart = broken;
            end
        end

        // Largest sizes, each clamped to 1024: the start of one wide row and
        // the start of one tall column
        write_reg(REG_KERNEL_TOP, rand_coef_row());
        write_reg(REG_KERNEL_MID, rand_coef_row());
        write_reg(REG_KERNEL_BOT, rand_coef_row());
        write_size(REG_IMAGE_WIDTH, 2047);
        write_size(REG_IMAGE_HEIGHT, 1);
        for (int i = 0; i < CLAMP_ITEMS; i++)
        begin
            px.req_type    = REQ_PIXEL;
            px.pixel_value = rand_pixel();
            send_pixel(px, 1'b0, '0);
        end
        write_size(REG_IMAGE_WIDTH, 1);
        write_size(REG_IMAGE_HEIGHT, 2047);
        for (int i = 0; i < CLAMP_ITEMS; i++)
        begin
            px.req_type    = REQ_PIXEL;
            px.pixel_value = rand_pixel();
            send_pixel(px, 1'b0, '0);
        end

        // Drain what is still owed, then watch for strays
        in_valid <= 1'b0;
        drain_wait = 0;
        while (sums_due.size() != 0 && drain_wait < END_WAIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sums_due.size() != 0)
            flag_mismatch($sformatf("%0d output pixels never arrived", sums_due.size()));

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
